// ===== hw/rtl/tun_pkg.sv =====
// Package for the triangle unit normal block: default sizes, threshold widths
// and configuration register codes.
// No dependencies.
package tun_pkg;

    localparam int COORD_WIDTH      = 32;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_W         = 16;
    localparam int N_IN_FIELDS      = 9;
    localparam int EDGE_THR_W       = 16;
    localparam int LEN_THR_W        = 32;
    localparam int CFG_DATA_W       = 32;
    localparam int CFG_INDEX_W      = 1;
    localparam int MUL_CHUNK        = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EDGE_NEAR_ZERO   = 1'b0,
        CFG_LENGTH_NEAR_ZERO = 1'b1
    } t_cfg_reg;

endpackage

// ===== hw/rtl/triangle_unit_normal.sv =====
// Triangle unit normal: edge vectors, cross product, square-root length and
// per-component division in one stall-able pipeline.
// Depends on tun_pkg.
//
// One triangle enters per cycle and one result leaves per cycle while the
// output is not held. Nine stages form the edges, the cross product and the
// squared length, then the square root takes one stage per result bit
// (2*COORD_WIDTH + 3 stages), one stage applies the length threshold, and
// the three divisions run side by side with one stage per quotient bit
// (NORMAL_FRAC_BITS + 1 stages) before the output register. A held output
// stalls the whole pipeline; nothing is lost or repeated. Degenerate
// triangles come out in order with a zero normal and m_tuser set. Write the
// thresholds only while no triangle is in flight.
module triangle_unit_normal #(
    parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH,
    parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // slave side
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest first), zero padded
    input  logic [((tun_pkg::N_IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // master side
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // normal_x, normal_y, normal_z (lowest first)
    output logic [3*tun_pkg::NORMAL_W-1:0]            m_tdata,
    // degenerate
    output logic                                      m_tuser,
    // configuration writes
    input  logic                                      i_cfg_wr_en,
    input  logic [tun_pkg::CFG_INDEX_W-1:0]           i_cfg_index,
    input  logic [tun_pkg::CFG_DATA_W-1:0]            i_cfg_wdata
);

    localparam int EW   = COORD_WIDTH + 1;
    localparam int H    = (EW + 1) / 2;
    localparam int PW   = 2 * EW;
    localparam int XW   = PW + 1;
    localparam int CH   = tun_pkg::MUL_CHUNK;
    localparam int NC   = (PW + CH - 1) / CH;
    localparam int PADW = NC * CH;
    localparam int SW   = 2 * PW;
    localparam int RW   = PW + 1;
    localparam int RADW = 2 * RW;
    localparam int QB   = NORMAL_FRAC_BITS + 1;
    localparam int DW   = RW + 1;
    localparam int NW   = tun_pkg::NORMAL_W;
    localparam int NQW  = (QB + 1 > NW) ? QB + 1 : NW;

    logic w_adv;

    // configuration
    logic [tun_pkg::EDGE_THR_W-1:0] r_edge_thr;
    logic [tun_pkg::LEN_THR_W-1:0]  r_len_thr;

    // stage 1: edges
    logic                 r1_vld;
    logic signed [EW-1:0] r1_e1 [0:2];
    logic signed [EW-1:0] r1_e2 [0:2];
    logic signed [EW-1:0] n1_e1 [0:2];
    logic signed [EW-1:0] n1_e2 [0:2];

    // stage 2: edge test, partial products
    logic                        r2_vld, r2_deg, n2_deg;
    logic signed [EW+H:0]        r2_plo [0:5];
    logic signed [EW+H:0]        n2_plo [0:5];
    logic signed [2*EW-H-1:0]    r2_phi [0:5];
    logic signed [2*EW-H-1:0]    n2_phi [0:5];

    // stage 3: products
    logic                 r3_vld, r3_deg;
    logic signed [PW-1:0] r3_prod [0:5];
    logic signed [PW-1:0] n3_prod [0:5];

    // stage 4: cross product
    logic                 r4_vld, r4_deg;
    logic signed [XW-1:0] r4_cross [0:2];
    logic signed [XW-1:0] n4_cross [0:2];

    // stages 5..8: magnitude, square partial products, rows, squares
    logic          r5_vld, r5_deg, r6_vld, r6_deg, r7_vld, r7_deg, r8_vld, r8_deg;
    logic          r5_neg [0:2];
    logic          n5_neg [0:2];
    logic          r6_neg [0:2];
    logic          r7_neg [0:2];
    logic          r8_neg [0:2];
    logic [PW-1:0] r5_mag [0:2];
    logic [PW-1:0] n5_mag [0:2];
    logic [PW-1:0] r6_mag [0:2];
    logic [PW-1:0] r7_mag [0:2];
    logic [PW-1:0] r8_mag [0:2];
    logic [2*CH-1:0]   r6_pp  [0:2][0:NC-1][0:NC-1];
    logic [2*CH-1:0]   n6_pp  [0:2][0:NC-1][0:NC-1];
    logic [2*PADW-1:0] r7_row [0:2][0:NC-1];
    logic [2*PADW-1:0] n7_row [0:2][0:NC-1];
    logic [SW-1:0]     r8_sq  [0:2];
    logic [SW-1:0]     n8_sq  [0:2];

    // square root stages; entry 0 holds the sum of squares
    logic            r_sq_vld  [0:RW];
    logic            r_sq_deg  [0:RW];
    logic            r_sq_neg  [0:RW][0:2];
    logic [PW-1:0]   r_sq_mag  [0:RW][0:2];
    logic [RADW-1:0] r_sq_rad  [0:RW];
    logic [RADW-1:0] n_sq_rad  [0:RW];
    logic [RW+1:0]   r_sq_rem  [0:RW];
    logic [RW+1:0]   n_sq_rem  [0:RW];
    logic [RW-1:0]   r_sq_root [0:RW];
    logic [RW-1:0]   n_sq_root [0:RW];

    // division stages; entry 0 holds the thresholded length
    logic          r_dv_vld [0:QB];
    logic          r_dv_deg [0:QB];
    logic          n_dv_deg;
    logic          r_dv_neg [0:QB][0:2];
    logic [RW-1:0] r_dv_len [0:QB];
    logic [DW-1:0] r_dv_rem [0:QB][0:2];
    logic [DW-1:0] n_dv_rem [0:QB][0:2];
    logic [QB-1:0] r_dv_q   [0:QB][0:2];
    logic [QB-1:0] n_dv_q   [0:QB][0:2];
    logic          r_dv_b0  [0:2];
    logic          n_dv_b0  [0:2];

    // output register
    logic          r_out_vld, r_out_deg;
    logic [NW-1:0] r_out_n [0:2];
    logic [NW-1:0] n_out_n [0:2];

    // advance everything unless a finished result is held
    assign w_adv    = !r_out_vld || m_tready;
    assign s_tready = w_adv;
    assign m_tvalid = r_out_vld;
    assign m_tuser  = r_out_deg;
    assign m_tdata  = {r_out_n[2], r_out_n[1], r_out_n[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_thr <= '0;
            r_len_thr  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (tun_pkg::t_cfg_reg'(i_cfg_index))
                tun_pkg::CFG_EDGE_NEAR_ZERO: begin
                    r_edge_thr <= i_cfg_wdata[tun_pkg::EDGE_THR_W-1:0];
                end
                tun_pkg::CFG_LENGTH_NEAR_ZERO: begin
                    r_len_thr <= i_cfg_wdata[tun_pkg::LEN_THR_W-1:0];
                end
            endcase
        end
    end

    always_comb begin : datapath
        logic signed [COORD_WIDTH-1:0] v_va, v_vb, v_vc;
        logic [EW-1:0]        v_abs1, v_abs2;
        logic                 v_small1, v_small2;
        logic signed [EW-1:0] v_pa [0:5];
        logic signed [EW-1:0] v_pb [0:5];
        logic signed [XW-1:0] v_negc;
        logic [PADW-1:0]      v_pad;
        logic [2*PADW-1:0]    v_acc;
        logic [RW+1:0]        v_rsh, v_trial;
        logic [DW-1:0]        v_dsh;
        logic [NQW-1:0]       v_qs;

        // edges from the first vertex
        for (int i = 0; i < 3; i++) begin
            v_va = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
            v_vb = s_tdata[(3+i)*COORD_WIDTH +: COORD_WIDTH];
            v_vc = s_tdata[(6+i)*COORD_WIDTH +: COORD_WIDTH];
            n1_e1[i] = EW'(v_vb) - EW'(v_va);
            n1_e2[i] = EW'(v_vc) - EW'(v_va);
        end

        // near-zero edge test and split products
        v_small1 = 1'b1;
        v_small2 = 1'b1;
        for (int i = 0; i < 3; i++) begin
            v_abs1 = r1_e1[i][EW-1] ? $unsigned(-r1_e1[i]) : $unsigned(r1_e1[i]);
            v_abs2 = r1_e2[i][EW-1] ? $unsigned(-r1_e2[i]) : $unsigned(r1_e2[i]);
            if (v_abs1 > EW'(r_edge_thr)) v_small1 = 1'b0;
            if (v_abs2 > EW'(r_edge_thr)) v_small2 = 1'b0;
        end
        n2_deg = v_small1 || v_small2;
        v_pa[0] = r1_e1[1]; v_pb[0] = r1_e2[2];
        v_pa[1] = r1_e1[2]; v_pb[1] = r1_e2[1];
        v_pa[2] = r1_e1[2]; v_pb[2] = r1_e2[0];
        v_pa[3] = r1_e1[0]; v_pb[3] = r1_e2[2];
        v_pa[4] = r1_e1[0]; v_pb[4] = r1_e2[1];
        v_pa[5] = r1_e1[1]; v_pb[5] = r1_e2[0];
        for (int k = 0; k < 6; k++) begin
            n2_plo[k] = v_pa[k] * $signed({1'b0, v_pb[k][H-1:0]});
            n2_phi[k] = v_pa[k] * $signed(v_pb[k][EW-1:H]);
        end

        for (int k = 0; k < 6; k++) begin
            n3_prod[k] = PW'(r2_plo[k]) + (PW'(r2_phi[k]) <<< H);
        end

        for (int i = 0; i < 3; i++) begin
            n4_cross[i] = XW'(r3_prod[2*i]) - XW'(r3_prod[2*i+1]);
        end

        for (int i = 0; i < 3; i++) begin
            v_negc    = -r4_cross[i];
            n5_neg[i] = r4_cross[i][XW-1];
            n5_mag[i] = n5_neg[i] ? v_negc[PW-1:0] : r4_cross[i][PW-1:0];
        end

        // squares from chunk products
        for (int i = 0; i < 3; i++) begin
            v_pad = PADW'(r5_mag[i]);
            for (int a = 0; a < NC; a++) begin
                for (int b = 0; b < NC; b++) begin
                    n6_pp[i][a][b] = v_pad[a*CH +: CH] * v_pad[b*CH +: CH];
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            for (int a = 0; a < NC; a++) begin
                v_acc = '0;
                for (int b = 0; b < NC; b++) begin
                    v_acc = v_acc + ((2*PADW)'(r6_pp[i][a][b]) << (CH*b));
                end
                n7_row[i][a] = v_acc;
            end
        end
        for (int i = 0; i < 3; i++) begin
            v_acc = '0;
            for (int a = 0; a < NC; a++) begin
                v_acc = v_acc + (r7_row[i][a] << (CH*a));
            end
            n8_sq[i] = v_acc[SW-1:0];
        end

        // sum of squares, then one root bit per stage
        n_sq_rad[0]  = RADW'(r8_sq[0]) + RADW'(r8_sq[1]) + RADW'(r8_sq[2]);
        n_sq_rem[0]  = '0;
        n_sq_root[0] = '0;
        for (int k = 0; k < RW; k++) begin
            v_rsh   = {r_sq_rem[k][RW-1:0], r_sq_rad[k][RADW-1 -: 2]};
            v_trial = {r_sq_root[k], 2'b01};
            if (v_rsh >= v_trial) begin
                n_sq_rem[k+1]  = v_rsh - v_trial;
                n_sq_root[k+1] = {r_sq_root[k][RW-2:0], 1'b1};
            end else begin
                n_sq_rem[k+1]  = v_rsh;
                n_sq_root[k+1] = {r_sq_root[k][RW-2:0], 1'b0};
            end
            n_sq_rad[k+1] = {r_sq_rad[k][RADW-3:0], 2'b00};
        end

        // length threshold and division setup
        n_dv_deg = r_sq_deg[RW] || (r_sq_root[RW] <= RW'(r_len_thr));
        for (int i = 0; i < 3; i++) begin
            n_dv_rem[0][i] = DW'(r_sq_mag[RW][i] >> 1);
            n_dv_b0[i]     = r_sq_mag[RW][i][0];
            n_dv_q[0][i]   = '0;
        end

        // one quotient bit per stage
        for (int k = 0; k < QB; k++) begin
            for (int i = 0; i < 3; i++) begin
                v_dsh = {r_dv_rem[k][i][RW-1:0], (k == 0) ? r_dv_b0[i] : 1'b0};
                if (v_dsh >= DW'(r_dv_len[k])) begin
                    n_dv_rem[k+1][i] = v_dsh - DW'(r_dv_len[k]);
                    n_dv_q[k+1][i]   = {r_dv_q[k][i][QB-2:0], 1'b1};
                end else begin
                    n_dv_rem[k+1][i] = v_dsh;
                    n_dv_q[k+1][i]   = {r_dv_q[k][i][QB-2:0], 1'b0};
                end
            end
        end

        // sign and zero for degenerate
        for (int i = 0; i < 3; i++) begin
            v_qs = NQW'(r_dv_q[QB][i]);
            if (r_dv_neg[QB][i]) v_qs = -v_qs;
            n_out_n[i] = r_dv_deg[QB] ? '0 : v_qs[NW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
            for (int k = 0; k <= RW; k++) r_sq_vld[k] <= 1'b0;
            for (int k = 0; k <= QB; k++) r_dv_vld[k] <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= s_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
            r_sq_vld[0] <= r8_vld;
            for (int k = 0; k < RW; k++) r_sq_vld[k+1] <= r_sq_vld[k];
            r_dv_vld[0] <= r_sq_vld[RW];
            for (int k = 0; k < QB; k++) r_dv_vld[k+1] <= r_dv_vld[k];
            r_out_vld <= r_dv_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_e1   <= n1_e1;
            r1_e2   <= n1_e2;
            r2_deg  <= n2_deg;
            r2_plo  <= n2_plo;
            r2_phi  <= n2_phi;
            r3_deg  <= r2_deg;
            r3_prod <= n3_prod;
            r4_deg  <= r3_deg;
            r4_cross <= n4_cross;
            r5_deg  <= r4_deg;
            r5_neg  <= n5_neg;
            r5_mag  <= n5_mag;
            r6_deg  <= r5_deg;
            r6_neg  <= r5_neg;
            r6_mag  <= r5_mag;
            r6_pp   <= n6_pp;
            r7_deg  <= r6_deg;
            r7_neg  <= r6_neg;
            r7_mag  <= r6_mag;
            r7_row  <= n7_row;
            r8_deg  <= r7_deg;
            r8_neg  <= r7_neg;
            r8_mag  <= r7_mag;
            r8_sq   <= n8_sq;
            r_sq_deg[0] <= r8_deg;
            r_sq_neg[0] <= r8_neg;
            r_sq_mag[0] <= r8_mag;
            for (int k = 0; k < RW; k++) begin
                r_sq_deg[k+1] <= r_sq_deg[k];
                r_sq_neg[k+1] <= r_sq_neg[k];
                r_sq_mag[k+1] <= r_sq_mag[k];
            end
            r_sq_rad  <= n_sq_rad;
            r_sq_rem  <= n_sq_rem;
            r_sq_root <= n_sq_root;
            r_dv_deg[0] <= n_dv_deg;
            r_dv_neg[0] <= r_sq_neg[RW];
            r_dv_len[0] <= r_sq_root[RW];
            r_dv_b0     <= n_dv_b0;
            for (int k = 0; k < QB; k++) begin
                r_dv_deg[k+1] <= r_dv_deg[k];
                r_dv_neg[k+1] <= r_dv_neg[k];
                r_dv_len[k+1] <= r_dv_len[k];
            end
            r_dv_rem  <= n_dv_rem;
            r_dv_q    <= n_dv_q;
            r_out_deg <= r_dv_deg[QB];
            r_out_n   <= n_out_n;
        end
    end

    // a degenerate result carries a zero normal
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result with nonzero normal");

    // an accepted transaction lands in the first stage
    a_in_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> r1_vld)
        else $error("accepted transaction lost at entry");

    // a stall freezes the pipeline
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r1_vld) && $stable(r_sq_vld[0]) && $stable(r_dv_vld[0]))
        else $error("pipeline moved during a stall");

    // a kept triangle has a nonzero length
    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[0] && !r_dv_deg[0] |-> r_dv_len[0] != '0)
        else $error("zero length passed the threshold");

    // the final division remainder stays below the length
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[QB] && !r_dv_deg[QB] |-> r_dv_rem[QB][0] < DW'(r_dv_len[QB]))
        else $error("division remainder out of range");

endmodule
